// ===== rtl/core/kfe_pkg.sv =====
// Package for the keyword field extractor: parse phases, register indexes,
// the configuration bundle and the result word.
// No dependencies.
package kfe_pkg;

  localparam int MAX_KEYWORD_DEF = 8;
  localparam int CfgIdxW = 4;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [CfgIdxW-1:0] CFG_KEYWORD_BYTES  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_KEYWORD_LENGTH = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_FIELD_SELECT   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_MAX_CHARS      = CfgIdxW'(3);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_LEAD,
    PH_SCAN,
    PH_AFTER_COMMA,
    PH_COPY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [63:0] keyword_bytes;
    logic [3:0]  keyword_length;
    logic [7:0]  field_select;
    logic [7:0]  max_chars;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    logic       success;
  } res_t;

endpackage

// ===== rtl/core/kfe_ifs.sv =====
// Valid/ready channel interfaces: text input, result output, register writes.
// Depends on kfe_pkg.
interface kfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface kfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       done_res;
  logic       success;
  modport source (output valid, out_char, char_valid, done_res, success, input ready);
  modport sink (input valid, out_char, char_valid, done_res, success, output ready);
endinterface

interface kfe_cfg_if import kfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] reg_index;
  logic [63:0]        wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/keyword_field_extractor_unit.sv =====
// Keyword field extractor, top level.
// Depends on kfe_pkg, kfe_ifs, kfe_core and kfe_skid.
//
// text_in takes one text word per cycle while it is ready (a byte plus an end-of-text flag).
// The parser hunts for the configured keyword, skips blanks, counts comma
// separated fields and streams the selected field out on res_out, one
// character per result word, with a final word carrying done_res/success.
// A word whose byte causes nothing produces no result.
// cfg is always ready; write registers 0..3 (keyword bytes, keyword length,
// field select, max chars) only while no text is in flight.
// Each result word is registered into the result buffer as its text word is
// accepted. Throughput: one text word per cycle while ready is high, set by
// the combinational parse step between input handshake and result register.
// When res_out stalls, one more result fits in the skid register; text_in
// then drops ready until the output register drains.
// Reset (rst, synchronous) returns the parser to keyword search, clears the
// result buffer and loads the register defaults (max chars 255, others 0).
module keyword_field_extractor_unit import kfe_pkg::*; #(
  parameter int MaxKeyword = MAX_KEYWORD_DEF
) (
  input logic         clk,
  input logic         rst,
  kfe_in_if.sink      text_in,
  kfe_out_if.source   res_out,
  kfe_cfg_if.sink     cfg
);

  cfg_t   cfg_regs;
  logic   in_fire;
  logic   res_valid;
  res_t   res;
  res_t   out_word;
  phase_t phase;
  logic   push_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.keyword_bytes  <= '0;
      cfg_regs.keyword_length <= '0;
      cfg_regs.field_select   <= '0;
      cfg_regs.max_chars      <= 8'hFF;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_KEYWORD_BYTES:  cfg_regs.keyword_bytes  <= cfg.wdata;
        CFG_KEYWORD_LENGTH: cfg_regs.keyword_length <= cfg.wdata[3:0];
        CFG_FIELD_SELECT:   cfg_regs.field_select   <= cfg.wdata[7:0];
        CFG_MAX_CHARS:      cfg_regs.max_chars      <= cfg.wdata[7:0];
        default: ;
      endcase
    end
  end

  assign text_in.ready = push_ready;
  assign in_fire       = text_in.valid && push_ready;

  kfe_core #(.MaxKeyword(MaxKeyword)) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .text_byte   (text_in.text_byte),
    .end_of_text (text_in.end_of_text),
    .cfg         (cfg_regs),
    .res_valid   (res_valid),
    .res         (res),
    .phase       (phase)
  );

  kfe_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_fire && res_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .pop_valid  (res_out.valid),
    .pop_data   (out_word),
    .pop_ready  (res_out.ready)
  );

  assign res_out.out_char   = out_word.out_char;
  assign res_out.char_valid = out_word.char_valid;
  assign res_out.done_res   = out_word.done_res;
  assign res_out.success    = out_word.success;

  // Input back-pressure only comes from a full result buffer.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !text_in.ready |-> res_out.valid)
    else $error("text_in stalled with no result pending");

  a_success_with_done: assert property (@(posedge clk) disable iff (rst)
    res_out.valid |-> (!res_out.success || res_out.done_res))
    else $error("success without done_res");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (res_out.valid && !res_out.char_valid) |-> (res_out.out_char == 8'h00))
    else $error("out_char nonzero without char_valid");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (in_fire && text_in.end_of_text) |=> (phase == PH_SEARCH))
    else $error("end of text did not re-arm the search");

endmodule

// ===== rtl/core/kfe_core.sv =====
// Parse state and next-state logic: keyword window compare, field counting
// and character copy, one text word per accepted cycle.
// Depends on kfe_pkg.
module kfe_core import kfe_pkg::*; #(
  parameter int MaxKeyword = MAX_KEYWORD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res,
  output phase_t     phase
);

  // The window holds the MaxKeyword-1 bytes before the newest one.
  localparam int WinW = (MaxKeyword > 1) ? (MaxKeyword - 1) * 8 : 8;
  localparam int CntW = $clog2(MaxKeyword + 1);

  phase_t            phase_next;
  logic [WinW-1:0]   recent_bytes, recent_bytes_next;
  logic [CntW-1:0]   bytes_seen, bytes_seen_next;
  logic [7:0]        field_count, field_count_next;
  logic [7:0]        chars_copied, chars_copied_next;

  phase_t            ph_eff;
  logic [CntW-1:0]   kw_n;
  logic [CntW-1:0]   seen_inc;
  logic [WinW+7:0]   win;
  logic              kw_match;
  logic              is_blank, is_nul, is_comma, copy_end;
  logic              do_copy, do_fail;
  logic [7:0]        copied_inc;

  // Clamp the keyword length to MaxKeyword (the window plus the newest byte).
  always_comb begin
    if (cfg.keyword_length > 4'(MaxKeyword)) kw_n = CntW'(MaxKeyword);
    else kw_n = CntW'(cfg.keyword_length);
  end

  assign win      = {recent_bytes, text_byte};
  assign seen_inc = (bytes_seen < CntW'(MaxKeyword)) ? bytes_seen + CntW'(1) : bytes_seen;

  // Keyword byte i sits kw_n-1-i words back from the newest byte.
  always_comb begin
    logic [CntW-1:0] pos;
    kw_match = (seen_inc >= kw_n);
    pos      = '0;
    for (int i = 0; i < MaxKeyword; i++) begin
      if (CntW'(i) < kw_n) begin
        pos = kw_n - CntW'(i) - CntW'(1);
        if (cfg.keyword_bytes[8*i +: 8] != win[8*pos +: 8]) begin
          kw_match = 1'b0;
        end
      end
    end
  end

  assign is_blank   = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
  assign is_nul     = (text_byte == CH_NUL);
  assign is_comma   = (text_byte == CH_COMMA);
  assign copy_end   = is_nul || is_comma || (text_byte == CH_CR) || (text_byte == CH_LF) ||
                      (chars_copied >= cfg.max_chars);
  assign copied_inc = chars_copied + 8'd1;
  assign ph_eff     = (phase == PH_SEARCH && kw_n == '0) ? PH_LEAD : phase;

  always_comb begin
    phase_next        = ph_eff;
    recent_bytes_next = recent_bytes;
    bytes_seen_next   = bytes_seen;
    field_count_next  = field_count;
    chars_copied_next = chars_copied;
    res_valid         = 1'b0;
    res               = '0;
    do_copy           = 1'b0;
    do_fail           = 1'b0;

    if (end_of_text) begin
      // Flush a pending final result, then re-arm.
      res_valid         = (phase != PH_DONE);
      res.done_res      = (phase != PH_DONE);
      res.success       = (phase == PH_COPY);
      phase_next        = PH_SEARCH;
      recent_bytes_next = '0;
      bytes_seen_next   = '0;
      field_count_next  = '0;
      chars_copied_next = '0;
    end else begin
      case (ph_eff)
        PH_SEARCH: begin
          if (is_nul) begin
            do_fail = 1'b1;
          end else begin
            recent_bytes_next = win[WinW-1:0];
            bytes_seen_next   = seen_inc;
            if (kw_match) phase_next = PH_LEAD;
          end
        end
        PH_LEAD, PH_AFTER_COMMA: begin
          if (!is_blank) begin
            if (is_nul) begin
              do_fail = 1'b1;
            end else if (field_count == cfg.field_select) begin
              do_copy = 1'b1;
            end else if (is_comma) begin
              field_count_next = field_count + 8'd1;
              phase_next       = PH_AFTER_COMMA;
            end else begin
              phase_next = PH_SCAN;
            end
          end
        end
        PH_SCAN: begin
          if (is_nul) begin
            do_fail = 1'b1;
          end else if (is_comma) begin
            field_count_next = field_count + 8'd1;
            phase_next       = PH_AFTER_COMMA;
          end
        end
        PH_COPY: begin
          do_copy = 1'b1;
        end
        default: ;
      endcase

      if (do_fail) begin
        res_valid    = 1'b1;
        res.done_res = 1'b1;
        phase_next   = PH_DONE;
      end

      if (do_copy) begin
        res_valid  = 1'b1;
        phase_next = PH_COPY;
        if (copy_end) begin
          res.done_res = 1'b1;
          res.success  = 1'b1;
          phase_next   = PH_DONE;
        end else begin
          chars_copied_next = copied_inc;
          res.out_char      = text_byte;
          res.char_valid    = 1'b1;
          if (copied_inc >= cfg.max_chars) begin
            res.done_res = 1'b1;
            res.success  = 1'b1;
            phase_next   = PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      recent_bytes <= '0;
      bytes_seen   <= '0;
      field_count  <= '0;
      chars_copied <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      recent_bytes <= recent_bytes_next;
      bytes_seen   <= bytes_seen_next;
      field_count  <= field_count_next;
      chars_copied <= chars_copied_next;
    end
  end

endmodule

// ===== rtl/core/kfe_skid.sv =====
// Two-entry result buffer: output register plus skid register, so the
// parser keeps taking words while a result waits. Depends on kfe_pkg.
module kfe_skid import kfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  res_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output res_t pop_data,
  input  logic pop_ready
);

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic pop;

  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;
  assign pop        = main_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Input is held off; drain skid into main once main is taken.
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push_valid) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_data <= skid_data;
    end else if (push_valid) begin
      if (!main_valid || pop) main_data <= push_data;
      else skid_data <= push_data;
    end
  end

endmodule
